// ----- rtl/core/akf_pkg.sv -----
package akf_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int NOISE_WIDTH         = 31;
   localparam int PERIOD_WIDTH        = 16;
   localparam int TICK_WIDTH          = 32;
   localparam int CSR_INDEX_WIDTH     = 2;
   localparam int CSR_DATA_WIDTH      = 31;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_Q  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BIAS_Q   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEAS_R   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PERIOD   = 2'd3;

   localparam logic [NOISE_WIDTH-1:0]  RESET_ANGLE_Q = 31'd66;
   localparam logic [NOISE_WIDTH-1:0]  RESET_BIAS_Q  = 31'd197;
   localparam logic [NOISE_WIDTH-1:0]  RESET_MEAS_R  = 31'd1966;
   localparam logic [PERIOD_WIDTH-1:0] RESET_PERIOD  = 16'd1;

   // shared unit operations
   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

endpackage

// ----- rtl/core/akf_alu.sv -----
// shared arithmetic unit: saturating add/sub, serial shift-add multiply and
// restoring divide
module akf_alu #(
   parameter int VALUE_WIDTH = akf_pkg::VALUE_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = akf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  akf_pkg::op_type               op,
   input  logic signed [VALUE_WIDTH-1:0] a,
   input  logic signed [VALUE_WIDTH-1:0] b,
   output logic                          done,
   output logic signed [VALUE_WIDTH-1:0] result
);
   import akf_pkg::*;

   localparam int W  = VALUE_WIDTH;
   localparam int PW = 2 * W;              // product / quotient magnitude width
   localparam int DW = W + FRAC_BITS;      // dividend bits
   localparam int CW = $clog2(DW + 1);
   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV,
      S_FIN
   } state_type;

   state_type       state_ff;
   logic [CW-1:0]   count_ff;
   logic            neg_ff;
   logic            div_ff;
   logic            zero_ff;
   logic [PW-1:0]   acc_ff;      // product accumulator or quotient
   logic [PW-1:0]   mcand_ff;    // shifted multiplicand
   logic [W-1:0]    mplier_ff;
   logic [W:0]      rem_ff;
   logic [DW-1:0]   dividend_ff;
   logic [W-1:0]    dmag_ff;
   logic signed [W-1:0] result_ff;
   logic            done_ff;

   logic [W-1:0]    amag, bmag;
   logic signed [W:0] sum_wide;
   logic [W:0]      rem_shift;
   logic [PW-1:0]   mag_final;
   logic [W-1:0]    sat_out;
   logic [W:0]      lim;

   assign amag = a[W-1] ? W'(-a) : W'(a);
   assign bmag = b[W-1] ? W'(-b) : W'(b);

   always_comb begin
      if (op == OP_SUB) begin
         sum_wide = {a[W-1], a} - {b[W-1], b};
      end else begin
         sum_wide = {a[W-1], a} + {b[W-1], b};
      end
   end

   assign rem_shift = {rem_ff[W-1:0], dividend_ff[DW-1]};

   assign mag_final = div_ff ? acc_ff : (acc_ff >> FRAC_BITS);
   assign lim = {1'b0, VMAX} + (W+1)'(neg_ff);

   always_comb begin
      if (zero_ff) begin
         sat_out = '0;
      end else if (mag_final > PW'(lim)) begin
         sat_out = neg_ff ? VMIN : VMAX;
      end else if (neg_ff) begin
         sat_out = W'(-mag_final[W-1:0]);
      end else begin
         sat_out = mag_final[W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               // add and subtract results and done are registered directly from start
               done_ff <= start && (op == OP_ADD || op == OP_SUB);
               if (start) begin
                  neg_ff  <= a[W-1] ^ b[W-1];
                  zero_ff <= 1'b0;
                  acc_ff  <= '0;
                  case (op)
                     OP_ADD, OP_SUB: begin
                        if (sum_wide[W] != sum_wide[W-1]) begin
                           result_ff <= sum_wide[W] ? VMIN : VMAX;
                        end else begin
                           result_ff <= sum_wide[W-1:0];
                        end
                     end
                     OP_MUL: begin
                        div_ff    <= 1'b0;
                        mcand_ff  <= PW'(amag);
                        mplier_ff <= bmag;
                        count_ff  <= CW'(W);
                        state_ff  <= S_MUL;
                     end
                     default: begin
                        div_ff      <= 1'b1;
                        zero_ff     <= (bmag == '0);
                        dividend_ff <= {amag, {FRAC_BITS{1'b0}}};
                        dmag_ff     <= bmag;
                        rem_ff      <= '0;
                        count_ff    <= CW'(DW);
                        state_ff    <= S_DIV;
                     end
                  endcase
               end
            end
            S_MUL: begin
               done_ff <= 1'b0;
               if (mplier_ff[0]) begin
                  acc_ff <= acc_ff + mcand_ff;
               end
               mcand_ff  <= mcand_ff << 1;
               mplier_ff <= mplier_ff >> 1;
               count_ff  <= count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_DIV: begin
               done_ff <= 1'b0;
               dividend_ff <= dividend_ff << 1;
               if (rem_shift >= {1'b0, dmag_ff}) begin
                  rem_ff <= rem_shift - {1'b0, dmag_ff};
                  acc_ff <= {acc_ff[PW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_shift;
                  acc_ff <= {acc_ff[PW-2:0], 1'b0};
               end
               count_ff <= count_ff - 1'b1;
               if (count_ff == CW'(1)) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               result_ff <= sat_out;
               done_ff   <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: begin
               done_ff  <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ----- rtl/core/angle_kalman_fusion_filter.sv -----
// channel  | direction | handshake          | payload
// req      | in        | req_valid/req_stall | tick_now, measured_angle, measured_rate
// rsp      | out       | rsp_valid/rsp_stall | angle_estimate, bias_estimate, updated
// csr      | in        | csr_write_enable   | csr_index, csr_data
//
// a held beat (period not elapsed) goes straight to the output without an update;
// an update runs 25 shared-unit operations in sequence (adds, multiplies and the two
// divides) on akf_alu, whose multiplier and divider are serial.
// reset (synchronous) clears state, covariance, last tick and loads the csr defaults.
// req_stall is high while a beat is in work or its result waits; rsp holds under stall.
module angle_kalman_fusion_filter #(
   parameter int VALUE_WIDTH = akf_pkg::VALUE_WIDTH_DEFAULT,
   parameter int FRAC_BITS   = akf_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [akf_pkg::TICK_WIDTH-1:0]          req_tick_now,
   input  logic signed [VALUE_WIDTH-1:0]           req_measured_angle,
   input  logic signed [VALUE_WIDTH-1:0]           req_measured_rate,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [VALUE_WIDTH-1:0]           rsp_angle_estimate,
   output logic signed [VALUE_WIDTH-1:0]           rsp_bias_estimate,
   output logic                                    rsp_updated,
   input  logic                                    csr_write_enable,
   input  logic [akf_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [akf_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import akf_pkg::*;

   localparam int W = VALUE_WIDTH;

   // noise value saturated to the signed value range
   function automatic logic [W-1:0] sat_noise(input logic [NOISE_WIDTH-1:0] v);
      logic [W-1:0] r;
      if (NOISE_WIDTH >= W && (v >> (W - 1)) != '0) begin
         r = {1'b0, {(W-1){1'b1}}};
      end else begin
         r = W'(v);
      end
      return r;
   endfunction

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_WAIT,
      S_OUT
   } state_type;

   // micro-op step numbers
   typedef enum logic [4:0] {
      M_T0,    // t = rate - bias
      M_ANG,   // angle = angle + t
      M_A1,    // t = p11 - p01
      M_A2,    // t = t - p10
      M_A3,    // t = t + qa
      M_P00,   // p00 = p00 + t
      M_P01,   // p01 = p01 - p11
      M_P10,   // p10 = p10 - p11
      M_P11,   // p11 = p11 + qb
      M_S,     // s = p00 + r
      M_K0,    // k0 = p00 / s
      M_K1,    // k1 = p10 / s
      M_Y,     // y = meas - angle
      M_M0,    // t = k0 * y
      M_ANG2,  // angle += t
      M_M1,    // t = k1 * y
      M_BIAS,  // bias += t
      M_M2,    // t = k0 * p00
      M_C00,   // n00 = p00 - t
      M_M3,    // t = k0 * p01
      M_C01,   // n01 = p01 - t
      M_M4,    // t = k1 * p00
      M_C10,   // p10 = p10 - t
      M_M5,    // t = k1 * p01
      M_C11    // p11 = p11 - t, commit
   } step_type;

   // csr registers
   logic [W-1:0]              qa_ff, qb_ff, r_ff;
   logic [PERIOD_WIDTH-1:0]   period_ff;

   // filter state
   logic signed [W-1:0] angle_ff, bias_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   logic [TICK_WIDTH-1:0] last_tick_ff;

   // work registers
   state_type           state_ff;
   step_type            step_ff;
   logic signed [W-1:0] tmp_ff, s_ff, k0_ff, k1_ff, y_ff, n00_ff, n01_ff;
   logic signed [W-1:0] meas_ff, rate_ff;
   logic [TICK_WIDTH-1:0] tick_ff;
   logic                updated_ff;

   // shared unit hookup
   logic                alu_start;
   op_type              alu_op;
   logic signed [W-1:0] alu_a, alu_b, alu_result;
   logic                alu_done;

   logic [TICK_WIDTH-1:0] elapsed;
   assign elapsed = req_tick_now - last_tick_ff;

   akf_alu #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .done   (alu_done),
      .result (alu_result)
   );

   // operand select for the current step
   always_comb begin
      alu_op = OP_ADD;
      alu_a  = tmp_ff;
      alu_b  = tmp_ff;
      unique case (step_ff)
         M_T0:   begin alu_op = OP_SUB; alu_a = rate_ff; alu_b = bias_ff; end
         M_ANG:  begin alu_a = angle_ff; alu_b = tmp_ff; end
         M_A1:   begin alu_op = OP_SUB; alu_a = p11_ff; alu_b = p01_ff; end
         M_A2:   begin alu_op = OP_SUB; alu_a = tmp_ff; alu_b = p10_ff; end
         M_A3:   begin alu_a = tmp_ff; alu_b = qa_ff; end
         M_P00:  begin alu_a = p00_ff; alu_b = tmp_ff; end
         M_P01:  begin alu_op = OP_SUB; alu_a = p01_ff; alu_b = p11_ff; end
         M_P10:  begin alu_op = OP_SUB; alu_a = p10_ff; alu_b = p11_ff; end
         M_P11:  begin alu_a = p11_ff; alu_b = qb_ff; end
         M_S:    begin alu_a = p00_ff; alu_b = r_ff; end
         M_K0:   begin alu_op = OP_DIV; alu_a = p00_ff; alu_b = s_ff; end
         M_K1:   begin alu_op = OP_DIV; alu_a = p10_ff; alu_b = s_ff; end
         M_Y:    begin alu_op = OP_SUB; alu_a = meas_ff; alu_b = angle_ff; end
         M_M0:   begin alu_op = OP_MUL; alu_a = k0_ff; alu_b = y_ff; end
         M_ANG2: begin alu_a = angle_ff; alu_b = tmp_ff; end
         M_M1:   begin alu_op = OP_MUL; alu_a = k1_ff; alu_b = y_ff; end
         M_BIAS: begin alu_a = bias_ff; alu_b = tmp_ff; end
         M_M2:   begin alu_op = OP_MUL; alu_a = k0_ff; alu_b = p00_ff; end
         M_C00:  begin alu_op = OP_SUB; alu_a = p00_ff; alu_b = tmp_ff; end
         M_M3:   begin alu_op = OP_MUL; alu_a = k0_ff; alu_b = p01_ff; end
         M_C01:  begin alu_op = OP_SUB; alu_a = p01_ff; alu_b = tmp_ff; end
         M_M4:   begin alu_op = OP_MUL; alu_a = k1_ff; alu_b = p00_ff; end
         M_C10:  begin alu_op = OP_SUB; alu_a = p10_ff; alu_b = tmp_ff; end
         M_M5:   begin alu_op = OP_MUL; alu_a = k1_ff; alu_b = p01_ff; end
         M_C11:  begin alu_op = OP_SUB; alu_a = p11_ff; alu_b = tmp_ff; end
         default: ;
      endcase
   end

   assign alu_start = (state_ff == S_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= M_T0;
         qa_ff        <= sat_noise(RESET_ANGLE_Q);
         qb_ff        <= sat_noise(RESET_BIAS_Q);
         r_ff         <= sat_noise(RESET_MEAS_R);
         period_ff    <= RESET_PERIOD;
         angle_ff     <= '0;
         bias_ff      <= '0;
         p00_ff       <= '0;
         p01_ff       <= '0;
         p10_ff       <= '0;
         p11_ff       <= '0;
         last_tick_ff <= '0;
         updated_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ANGLE_Q: qa_ff     <= sat_noise(NOISE_WIDTH'(csr_data));
               CSR_BIAS_Q:  qb_ff     <= sat_noise(NOISE_WIDTH'(csr_data));
               CSR_MEAS_R:  r_ff      <= sat_noise(NOISE_WIDTH'(csr_data));
               CSR_PERIOD:  period_ff <= csr_data[PERIOD_WIDTH-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  meas_ff <= req_measured_angle;
                  rate_ff <= req_measured_rate;
                  tick_ff <= req_tick_now;
                  step_ff <= M_T0;
                  if (elapsed >= TICK_WIDTH'(period_ff)) begin
                     updated_ff <= 1'b1;
                     state_ff   <= S_RUN;
                  end else begin
                     updated_ff <= 1'b0;
                     state_ff   <= S_OUT;
                  end
               end
            end
            S_RUN: state_ff <= S_WAIT;
            S_WAIT: begin
               if (alu_done) begin
                  // last step commits and hands the beat to the output
                  state_ff <= (step_ff == M_C11) ? S_OUT : S_RUN;
                  step_ff  <= step_type'(step_ff + 1'b1);
                  unique case (step_ff)
                     M_ANG, M_ANG2: angle_ff <= alu_result;
                     M_P00:  p00_ff <= alu_result;
                     M_P01:  p01_ff <= alu_result;
                     M_P10:  p10_ff <= alu_result;
                     M_P11:  p11_ff <= alu_result;
                     M_S:    s_ff   <= alu_result;
                     M_K0:   k0_ff  <= alu_result;
                     M_K1:   k1_ff  <= alu_result;
                     M_Y:    y_ff   <= alu_result;
                     M_BIAS: bias_ff <= alu_result;
                     M_C00:  n00_ff <= alu_result;
                     M_C01:  n01_ff <= alu_result;
                     M_C10:  p10_ff <= alu_result;
                     M_C11: begin
                        p11_ff       <= alu_result;
                        p00_ff       <= n00_ff;
                        p01_ff       <= n01_ff;
                        last_tick_ff <= tick_ff;
                     end
                     default: tmp_ff <= alu_result;
                  endcase
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_OUT);
   assign rsp_angle_estimate = angle_ff;
   assign rsp_bias_estimate  = bias_ff;
   assign rsp_updated        = updated_ff;

endmodule
